>>> rtl/core/piecewise_linear_interpolator_assert.svh
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_assert.svh
// Assertion macros shared by the interpolator RTL
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH

// checked only outside reset
`define PLI_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every clock edge, reset included
`define PLI_ASSERT_ALL(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Types and constants of the piecewise linear interpolator
// ----------------------------------------------------------------------------
package pli_pkg;

  // data format, signed fixed point
  localparam int unsigned DATA_WIDTH     = 32;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned MAX_POINTS_DEF = 16;

  // divider quotient width: magnitude shifted up by the fraction bits
  localparam int unsigned QUO_W = DATA_WIDTH + FRAC_BITS;

  // signed width of the fractional index before saturation
  localparam int unsigned POS_W = DATA_WIDTH + 4;

  // field widths fixed by the interface
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ENTRY_W = 4;
  localparam int unsigned SEG_W   = 4;
  localparam int unsigned COUNT_W = 5;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [0:0] {
    REG_POINT_COUNT = 1'b0,
    REG_SATURATE    = 1'b1
  } pli_reg_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_BP  = 2'd0,
    FUNC_WR_VAL = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NOP    = 2'd3
  } pli_func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_LOAD_LO,
    ST_LOAD_HI,
    ST_PREP,
    ST_DIV,
    ST_POS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ROUND,
    ST_FIN
  } pli_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic [ENTRY_W-1:0]           entry;
    logic signed [DATA_WIDTH-1:0] data;
  } pli_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic [SEG_W-1:0]             segment;
    logic signed [DATA_WIDTH-1:0] position;
    logic                         overflow;
  } pli_out_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } pli_div_stat_t;

endpackage

>>> rtl/core/pli_div.sv
// ----------------------------------------------------------------------------
// pli_div
// Iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pli_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pli_pkg::DATA_WIDTH-1:0] num_i,
  input  logic [pli_pkg::DATA_WIDTH-1:0] den_i,
  output pli_pkg::pli_div_stat_t         stat_o,
  output logic [pli_pkg::QUO_W-1:0]      quo_o
);
  import pli_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] den_q, den_d;
  logic [QUO_W-1:0]      quo_q, quo_d;
  logic [DATA_WIDTH:0]   cand;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  // one trial subtraction of the shifted remainder
  assign cand = {rem_q, quo_q[QUO_W-1]};
  assign diff = cand - {1'b0, den_q};
  assign ge   = cand >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CNT_W'(QUO_W);
      rem_d = '0;
      den_d = den_i;
      quo_d = QUO_W'(num_i) << FRAC_BITS;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      rem_d  = ge ? diff[DATA_WIDTH-1:0] : cand[DATA_WIDTH-1:0];
      quo_d  = {quo_q[QUO_W-2:0], ge};
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  // step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // remainder, divisor and quotient shift register
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

>>> rtl/core/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// A table of up to MAX_POINTS breakpoints and values in signed Q16.16, loaded
// one entry per input transfer (func 0 breakpoint, func 1 value); a query
// (func 2) returns the interpolated value, the segment, the fractional index
// and an overflow flag. Writes give no result. A query runs a linear segment
// search that compares up to point_count-2 breakpoints, each search step a
// table read and a compare, then the 48-step shared divider computes
// (x - low) / (high - low). A zero-width segment skips the divider. A query
// whose result finds the previous one still waiting holds in its last step
// until that one is taken. The input is not ready while a query runs. A
// finished result sits in an output register, so the next item can be taken
// while it waits. Breakpoints must be written before a query reads them;
// tables have no reset value. point_count is taken as 2 when below 2 and as
// MAX_POINTS when above it; saturate_mode clamps the index to the table ends.
// Registers: point_count at byte address 0, saturate_mode at 4.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
  parameter int unsigned MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pli_pkg::pli_in_t            in_data_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pli_pkg::pli_out_t           out_data_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pli_pkg::PADDR_W-1:0] paddr,
  input  logic [pli_pkg::PDATA_W-1:0] pwdata,
  output logic [pli_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import pli_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned QX_W = (QUO_W > POS_W) ? QUO_W : POS_W;
  localparam int unsigned HW   = (POS_W + 1) / 2;
  localparam int unsigned PRW  = DW + POS_W;
  localparam int unsigned V_W  = PRW + 1;

  // largest quotient kept, beyond any index the table can reach
  localparam logic [QX_W-1:0] QCAP =
    (QX_W'(1) << (DW + 1)) + (QX_W'(MAX_POINTS) << FRAC_BITS);
  localparam logic [PRW-1:0] FMASK = (PRW'(1) << FRAC_BITS) - PRW'(1);
  localparam logic signed [POS_W-1:0] POS_DMAX =
    $signed({{(POS_W-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [POS_W-1:0] POS_DMIN =
    $signed({{(POS_W-DW+1){1'b1}}, {(DW-1){1'b0}}});
  localparam logic signed [V_W-1:0] V_DMAX =
    $signed({{(V_W-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [V_W-1:0] V_DMIN =
    $signed({{(V_W-DW+1){1'b1}}, {(DW-1){1'b0}}});

  // control state
  pli_state_e          state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]  pc_q;
  logic                sat_q;

  // datapath registers
  pli_out_t                out_q;
  logic signed [DW-1:0]    x_q;
  logic [CW-1:0]           n_q;
  logic [AW-1:0]           idx_q;
  logic [AW-1:0]           seg_q;
  logic signed [DW-1:0]    bp_rd_q;
  logic signed [DW-1:0]    val_rd_q;
  logic signed [DW-1:0]    lo_q;
  logic signed [DW-1:0]    vlo_q;
  logic                    qneg_q;
  logic                    den_zero_q;
  logic [DW-1:0]           dzm_q;
  logic                    dzneg_q;
  logic signed [POS_W-1:0] pos_q;
  logic [POS_W-1:0]        tm_q;
  logic                    vneg_q;
  logic [PRW-1:0]          prod_q;
  logic signed [V_W-1:0]   vs_q;

  // table storage
  logic [DW-1:0] bp_mem  [MAX_POINTS];
  logic [DW-1:0] val_mem [MAX_POINTS];

  // handshake and sequencer controls
  logic          in_xfer;
  logic          is_query;
  logic          tbl_we_bp;
  logic          tbl_we_val;
  logic [AW-1:0] rd_addr;
  logic          div_start;
  logic          out_load;
  logic          cfg_we;

  // combinational datapath
  logic [CW-1:0]           n_clamp;
  logic                    srch_hit;
  logic                    srch_last;
  logic signed [DW:0]      num_s;
  logic signed [DW:0]      den_s;
  logic signed [DW:0]      dz_s;
  logic [DW:0]             num_m;
  logic [DW:0]             den_m;
  logic [DW:0]             dz_m;
  pli_div_stat_t           div_stat;
  logic [QUO_W-1:0]        div_quo;
  logic [QX_W-1:0]         q_x;
  logic [QX_W-1:0]         q_c;
  logic signed [POS_W-1:0] base_s;
  logic signed [POS_W-1:0] top_s;
  logic signed [POS_W-1:0] pos_raw;
  logic signed [POS_W-1:0] pos_cl;
  logic signed [POS_W-1:0] t_s;
  logic [POS_W-1:0]        t_m;
  logic [HW-1:0]           mul_b;
  logic [DW+HW-1:0]        mul_p;
  logic [PRW-1:0]          pm;
  logic                    rbit;
  logic [V_W-1:0]          pm_r;
  logic signed [V_W-1:0]   vs;
  logic signed [V_W-1:0]   val_sum;
  logic                    ovf_v;
  logic                    ovf_p;
  pli_out_t                res;

  // ------------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= COUNT_W'(2);
      sat_q <= 1'b0;
    end else if (cfg_we) begin
      case (pli_reg_e'(paddr[2])) 
        REG_POINT_COUNT: pc_q  <= pwdata[COUNT_W-1:0];
        REG_SATURATE:    sat_q <= pwdata[0];
        default:         sat_q <= sat_q;
      endcase
    end
  end

  always_comb begin
    case (pli_reg_e'(paddr[2]))
      REG_POINT_COUNT: prdata = PDATA_W'(pc_q);
      REG_SATURATE:    prdata = PDATA_W'(sat_q);
      default:         prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------------
  // input transfer decode
  // ------------------------------------------------------------------------
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_query   = (in_data_i.func == FUNC_QUERY);
  assign tbl_we_bp  = in_xfer && (in_data_i.func == FUNC_WR_BP) &&
                      (32'(in_data_i.entry) < MAX_POINTS);
  assign tbl_we_val = in_xfer && (in_data_i.func == FUNC_WR_VAL) &&
                      (32'(in_data_i.entry) < MAX_POINTS);

  // point count clamped to at least 2 and at most the table size
  always_comb begin
    n_clamp = CW'(pc_q);
    if (pc_q < COUNT_W'(2)) begin
      n_clamp = CW'(2);
    end else if (32'(pc_q) > MAX_POINTS) begin
      n_clamp = CW'(MAX_POINTS);
    end
  end

  // ------------------------------------------------------------------------
  // table memories, one write and one registered read each
  // ------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (tbl_we_bp) begin
      bp_mem[AW'(in_data_i.entry)] <= in_data_i.data;
    end
    if (tbl_we_val) begin
      val_mem[AW'(in_data_i.entry)] <= in_data_i.data;
    end
    bp_rd_q  <= bp_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  // ------------------------------------------------------------------------
  // sequencer: next state
  // ------------------------------------------------------------------------
  assign srch_hit  = (x_q < bp_rd_q);
  assign srch_last = (32'(idx_q) + 32'd2 == 32'(n_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && is_query) begin
          state_d = (n_clamp == CW'(2)) ? ST_LOAD_LO : ST_SRCH_RD;
        end
      end
      ST_SRCH_RD:  state_d = ST_SRCH_CMP;
      ST_SRCH_CMP: state_d = (srch_hit || srch_last) ? ST_LOAD_LO : ST_SRCH_RD;
      ST_LOAD_LO:  state_d = ST_LOAD_HI;
      ST_LOAD_HI:  state_d = ST_PREP;
      ST_PREP:     state_d = (den_s == '0) ? ST_POS : ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_POS;
        end
      end
      ST_POS:      state_d = ST_MUL_LO;
      ST_MUL_LO:   state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_ROUND;
      ST_ROUND:    state_d = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------------
  // sequencer: outputs
  // ------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    rd_addr    = seg_q;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:    in_ready_o = 1'b1;
      ST_SRCH_RD: rd_addr    = idx_q;
      ST_LOAD_LO: rd_addr    = seg_q;
      ST_LOAD_HI: rd_addr    = seg_q + AW'(1);
      ST_PREP:    div_start  = (den_s != '0);
      ST_FIN:     out_load   = !out_valid_q || out_ready_i;
      default:    rd_addr    = seg_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register, held until the output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ------------------------------------------------------------------------
  // segment differences and magnitudes
  // ------------------------------------------------------------------------
  assign num_s = $signed({x_q[DW-1], x_q}) - $signed({lo_q[DW-1], lo_q});
  assign den_s = $signed({bp_rd_q[DW-1], bp_rd_q}) - $signed({lo_q[DW-1], lo_q});
  assign dz_s  = $signed({val_rd_q[DW-1], val_rd_q}) - $signed({vlo_q[DW-1], vlo_q});
  assign num_m = num_s[DW] ? $unsigned(-num_s) : $unsigned(num_s);
  assign den_m = den_s[DW] ? $unsigned(-den_s) : $unsigned(den_s);
  assign dz_m  = dz_s[DW]  ? $unsigned(-dz_s)  : $unsigned(dz_s);

  // shared divider for the segment fraction
  pli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_m[DW-1:0]),
    .den_i   (den_m[DW-1:0]),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  // ------------------------------------------------------------------------
  // fractional index, with clamping in saturate mode
  // ------------------------------------------------------------------------
  always_comb begin
    q_x     = den_zero_q ? '0 : QX_W'(div_quo);
    q_c     = (q_x > QCAP) ? QCAP : q_x;
    base_s  = $signed(POS_W'(seg_q) << FRAC_BITS);
    top_s   = $signed(POS_W'(n_q - CW'(1)) << FRAC_BITS);
    pos_raw = qneg_q ? (base_s - $signed(POS_W'(q_c)))
                     : (base_s + $signed(POS_W'(q_c)));
    pos_cl  = pos_raw;
    if (sat_q) begin
      if (pos_raw < 0) begin
        pos_cl = '0;
      end else if (pos_raw > top_s) begin
        pos_cl = top_s;
      end
    end
    t_s = pos_cl - base_s;
    t_m = t_s[POS_W-1] ? $unsigned(-t_s) : $unsigned(t_s);
  end

  // ------------------------------------------------------------------------
  // one multiplier, used for the low then the high half of the fraction
  // ------------------------------------------------------------------------
  assign mul_b = (state_q == ST_MUL_LO) ? tm_q[HW-1:0] : HW'(tm_q[POS_W-1:HW]);
  assign mul_p = (DW+HW)'(dzm_q) * (DW+HW)'(mul_b);

  // floor of the signed product: round the magnitude up when negative
  always_comb begin
    pm   = prod_q >> FRAC_BITS;
    rbit = |(prod_q & FMASK);
    pm_r = V_W'(pm) + V_W'(rbit);
    vs   = vneg_q ? -$signed(pm_r) : $signed(V_W'(pm));
  end

  // final sum and saturation to the data width
  always_comb begin
    val_sum      = $signed({{(V_W-DW){vlo_q[DW-1]}}, vlo_q}) + vs_q;
    ovf_v        = (val_sum > V_DMAX) || (val_sum < V_DMIN);
    ovf_p        = (pos_q > POS_DMAX) || (pos_q < POS_DMIN);
    res.value    = (val_sum > V_DMAX) ? V_DMAX[DW-1:0] :
                   (val_sum < V_DMIN) ? V_DMIN[DW-1:0] : val_sum[DW-1:0];
    res.position = (pos_q > POS_DMAX) ? POS_DMAX[DW-1:0] :
                   (pos_q < POS_DMIN) ? POS_DMIN[DW-1:0] : pos_q[DW-1:0];
    res.segment  = SEG_W'(seg_q);
    res.overflow = ovf_v || ovf_p;
  end

  // ------------------------------------------------------------------------
  // datapath registers, loaded per sequencer step
  // ------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && is_query) begin
          x_q   <= in_data_i.data;
          n_q   <= n_clamp;
          idx_q <= AW'(1);
          seg_q <= '0;
        end
      end
      ST_SRCH_CMP: begin
        if (srch_hit) begin
          seg_q <= idx_q - AW'(1);
        end else if (srch_last) begin
          seg_q <= idx_q;
        end
        idx_q <= idx_q + AW'(1);
      end
      ST_LOAD_HI: begin
        lo_q  <= bp_rd_q;
        vlo_q <= val_rd_q;
      end
      ST_PREP: begin
        qneg_q     <= num_s[DW] ^ den_s[DW];
        den_zero_q <= (den_s == '0);
        dzm_q      <= dz_m[DW-1:0];
        dzneg_q    <= dz_s[DW];
      end
      ST_POS: begin
        pos_q  <= pos_cl;
        tm_q   <= t_m;
        vneg_q <= dzneg_q ^ t_s[POS_W-1];
      end
      ST_MUL_LO: prod_q <= PRW'(mul_p);
      ST_MUL_HI: prod_q <= prod_q + (PRW'(mul_p) << HW);
      ST_ROUND:  vs_q   <= vs;
      ST_FIN: begin
        if (out_load) begin
          out_q <= res;
        end
      end
      default: begin
        seg_q <= seg_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
`include "piecewise_linear_interpolator_assert.svh"

  `PLI_ASSERT_RST(a_query_leaves_idle, (in_xfer && is_query) |=> (state_q != ST_IDLE), "query transfer did not start the sequencer")
  `PLI_ASSERT_RST(a_div_done_in_div, div_stat.done |-> (state_q == ST_DIV), "divider finished outside the divide step")
  `PLI_ASSERT_RST(a_search_in_table, (state_q == ST_SRCH_RD) |-> (32'(idx_q) + 32'd1 < 32'(n_q)), "search index beyond the last segment")
  `PLI_ASSERT_RST(a_result_from_fin, $rose(out_valid_q) |-> ($past(state_q) == ST_FIN), "result appeared without a final step")
  `PLI_ASSERT_ALL(a_idle_div_quiet, in_ready_o |-> !div_stat.busy, "divider busy while the input is ready")

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piecewise linear interpolator. A driver sends
// table writes and queries from a queue and a monitor predicts each query
// result and compares it field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import pli_pkg::*;

  localparam int MAX_PTS = MAX_POINTS_DEF;
  localparam int DRAIN_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS = 180;
  localparam longint D_MAX = 64'sd2147483647;
  localparam longint D_MIN = -64'sd2147483648;
  localparam longint unsigned Q_CAP =
    (64'd1 << (DATA_WIDTH + 1)) + (64'(MAX_PTS) << FRAC_BITS);

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_QUARTER,
    RDY_TRICKLE
  } rdy_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pli_in_t              in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pli_out_t             out_item;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // stimulus and expectations
  pli_in_t  stim_q[$];
  pli_out_t expected_q[$];
  longint   gen_bp[MAX_PTS];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  logic     in_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  rdy_mode_e rdy_mode = RDY_ALWAYS;
  int       mode_left = 0;
  logic [6:0] stall_tick = '0;

  // predictor state
  longint     bp_tab[MAX_PTS];
  longint     val_tab[MAX_PTS];
  logic [4:0] point_cnt = 5'd2;
  logic       sat_on = 1'b0;

  piecewise_linear_interpolator #(
    .MAX_POINTS(MAX_PTS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #6 clk = ~clk;

  // saturate a wide value to the data width
  function automatic logic [31:0] clamp32(longint v);
    if (v > D_MAX) v = D_MAX;
    if (v < D_MIN) v = D_MIN;
    return v[31:0];
  endfunction

  function automatic longint rand_between(longint lo, longint hi);
    longint unsigned w;
    w = hi - lo;
    return lo + longint'({$urandom, $urandom} % (w + 1));
  endfunction

  // full-range or modest table value
  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom) >>> $urandom_range(4, 20);
  endfunction

  // segment search, fractional index and interpolation for one query
  function automatic pli_out_t interp_query(logic signed [31:0] x);
    pli_out_t res;
    int n, seg;
    longint xs, num, den, base, pos, t, dz, v, sum, top;
    longint unsigned num_m, den_m, quo, dz_m, t_m;
    logic [127:0] prod;
    logic neg_v, ovf;
    n = (point_cnt < 2) ? 2 : (point_cnt > MAX_PTS) ? MAX_PTS : int'(point_cnt);
    xs = x;
    // first breakpoint above x picks the segment below it
    seg = n - 2;
    for (int i = n - 2; i >= 1; i--)
      if (xs < bp_tab[i]) seg = i - 1;
    num = xs - bp_tab[seg];
    den = bp_tab[seg + 1] - bp_tab[seg];
    num_m = (num < 0) ? -num : num;
    den_m = (den < 0) ? -den : den;
    // zero-width segment leaves the fraction at zero
    quo = 0;
    if (den != 0) begin
      quo = (num_m << FRAC_BITS) / den_m;
      if (quo > Q_CAP) quo = Q_CAP;
    end
    base = longint'(seg) << FRAC_BITS;
    pos = ((num < 0) != (den < 0)) ? base - longint'(quo) : base + longint'(quo);
    if (sat_on) begin
      top = longint'(n - 1) << FRAC_BITS;
      if (pos < 0) pos = 0;
      if (pos > top) pos = top;
    end
    t = pos - base;
    // floor of the signed product scaled down by the fraction bits
    dz = val_tab[seg + 1] - val_tab[seg];
    dz_m = (dz < 0) ? -dz : dz;
    t_m = (t < 0) ? -t : t;
    prod = {64'd0, dz_m} * {64'd0, t_m};
    v = longint'(prod >> FRAC_BITS);
    neg_v = (dz < 0) != (t < 0);
    if (neg_v) begin
      if (|prod[FRAC_BITS-1:0]) v = v + 1;
      v = -v;
    end
    sum = val_tab[seg] + v;
    ovf = (sum > D_MAX) || (sum < D_MIN) || (pos > D_MAX) || (pos < D_MIN);
    res.value = clamp32(sum);
    res.segment = seg[SEG_W-1:0];
    res.position = clamp32(pos);
    res.overflow = ovf;
    return res;
  endfunction

  task automatic push_item(pli_func_e f, int e, logic [31:0] d);
    pli_in_t it;
    it.func = f;
    it.entry = e[ENTRY_W-1:0];
    it.data = d;
    stim_q.push_back(it);
    if (f == FUNC_WR_BP) gen_bp[e[ENTRY_W-1:0]] = longint'($signed(d));
  endtask

  // sorted breakpoints with random spacing, plus values
  task automatic load_sorted_table(int spacing);
    longint steps[MAX_PTS];
    longint total, cur;
    int i;
    total = 0;
    for (i = 1; i < MAX_PTS; i++) begin
      case (spacing)
        0: steps[i] = $urandom_range(0, 64);
        1: steps[i] = $urandom_range(1, 32'h0010_0000);
        default: steps[i] = $urandom_range(1, 32'h0800_0000);
      endcase
      total += steps[i];
    end
    cur = rand_between(D_MIN, D_MAX - total);
    for (i = 0; i < MAX_PTS; i++) begin
      if (i > 0) cur += steps[i];
      push_item(FUNC_WR_BP, i, cur[31:0]);
      push_item(FUNC_WR_VAL, i, rand_value());
    end
  endtask

  // query x: mostly around the table, some near breakpoints and extremes
  function automatic logic [31:0] pick_query_x(int n);
    longint lo, hi, span, tmp;
    int r;
    r = $urandom_range(0, 99);
    lo = gen_bp[0];
    hi = gen_bp[n - 1];
    if (lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    span = hi - lo;
    if (r < 55) return clamp32(rand_between(lo - span / 4, hi + span / 4));
    if (r < 70)
      return clamp32(gen_bp[$urandom_range(0, n - 1)] + longint'($urandom_range(0, 4)) - 2);
    if (r < 85) return $urandom;
    if (r < 92) return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    return $signed($urandom) >>> $urandom_range(8, 24);
  endfunction

  task automatic random_phase(int n_items, int n_pts);
    int k, r, e;
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      e = $urandom_range(0, MAX_PTS - 1);
      if (r < 70) push_item(FUNC_QUERY, e, pick_query_x(n_pts));
      else if (r < 80) push_item(FUNC_WR_VAL, e, rand_value());
      else if (r < 86)
        push_item(FUNC_WR_BP, e, clamp32(gen_bp[e] + longint'($urandom_range(0, 64)) - 32));
      else if (r < 90) push_item(FUNC_WR_BP, e, $urandom);
      else push_item(FUNC_NOP, e, $urandom);
    end
  endtask

  // setup and access cycle, register written when pready is seen
  task automatic reg_write(pli_reg_e idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_POINT_COUNT: point_cnt = val[COUNT_W-1:0];
      REG_SATURATE: sat_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold off until every transfer is done and the block has gone quiet
  task automatic wait_drained();
    while (stim_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(1, 8);
    return $urandom_range(9, 100);
  endfunction

  // input driver: bursts from the pending queue with gaps between them
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stim_q.size() != 0) begin
        in_valid <= 1'b1;
        in_item <= stim_q.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= pick_gap();
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, the pattern is picked anew at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      mode_left <= 0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      if (mode_left == 0) begin
        rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rdy_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_COIN: out_ready <= ($urandom_range(0, 1) == 1);
        RDY_QUARTER: out_ready <= (stall_tick[1:0] == 2'b11);
        default: out_ready <= (stall_tick == 7'h7f);
      endcase
    end
  end

  // monitor: update predictor on input transfers, check result transfers
  always @(posedge clk) begin : monitor
    pli_out_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        case (pli_func_e'(in_item.func))
          FUNC_WR_BP: bp_tab[in_item.entry] = longint'($signed(in_item.data));
          FUNC_WR_VAL: val_tab[in_item.entry] = longint'($signed(in_item.data));
          FUNC_QUERY: expected_q.push_back(interp_query(in_item.data));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %h seg %0d pos %h ovf %b",
                     out_item.value, out_item.segment, out_item.position,
                     out_item.overflow);
        end else begin
          want = expected_q.pop_front();
          if (out_item.value !== want.value || out_item.segment !== want.segment ||
              out_item.position !== want.position ||
              out_item.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value %h seg %0d pos %h ovf %b, got value %h seg %0d pos %h ovf %b",
                       want.value, want.segment, want.position, want.overflow,
                       out_item.value, out_item.segment, out_item.position,
                       out_item.overflow);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    int i, p, cnt, n_eff;
    logic sat_v;
    for (i = 0; i < MAX_PTS; i++) begin
      bp_tab[i] = 0;
      val_tab[i] = 0;
      gen_bp[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // evenly spaced table, every entry written before any query
    for (i = 0; i < MAX_PTS; i++) begin
      push_item(FUNC_WR_BP, i, (i - 8) * 32'sh0010_0000);
      push_item(FUNC_WR_VAL, i, (i * 7 - 50) * 32'sh0001_0000);
    end
    // reset configuration: two points, extrapolation
    push_item(FUNC_QUERY, 0, 32'h8000_0000);
    push_item(FUNC_QUERY, 0, 32'h7fff_ffff);
    push_item(FUNC_QUERY, 0, 32'hff80_0000);
    wait_drained();

    reg_write(REG_POINT_COUNT, 32'd16);
    reg_write(REG_SATURATE, 32'd0);
    // full table: ends, breakpoints, mid-segment, unused function code
    push_item(FUNC_QUERY, 0, 32'h8000_0000);
    push_item(FUNC_QUERY, 0, 32'h7fff_ffff);
    push_item(FUNC_QUERY, 0, 32'hff80_0000);
    push_item(FUNC_QUERY, 0, 32'h0070_0000);
    push_item(FUNC_QUERY, 0, 32'hfff0_8000);
    push_item(FUNC_NOP, 15, 32'hffff_ffff);
    // extreme values, extrapolation overflow below the table
    push_item(FUNC_WR_VAL, 0, 32'h8000_0000);
    push_item(FUNC_WR_VAL, 1, 32'h7fff_ffff);
    push_item(FUNC_QUERY, 0, 32'h8000_0000);
    push_item(FUNC_QUERY, 0, 32'hff88_0000);
    // zero-width last segment
    push_item(FUNC_WR_BP, 14, 32'h0070_0000);
    push_item(FUNC_QUERY, 0, 32'h7fff_ffff);
    push_item(FUNC_WR_BP, 14, 32'h0060_0000);
    // decreasing breakpoints at either end
    push_item(FUNC_WR_BP, 15, 32'h8000_0000);
    push_item(FUNC_QUERY, 0, 32'h7fff_ffff);
    push_item(FUNC_WR_BP, 15, 32'h0070_0000);
    push_item(FUNC_WR_BP, 0, 32'h7fff_ffff);
    push_item(FUNC_QUERY, 0, 32'hff8f_ffff);
    // zero-width first segment
    push_item(FUNC_WR_BP, 0, 32'hff90_0000);
    push_item(FUNC_QUERY, 0, 32'h8000_0000);
    push_item(FUNC_WR_BP, 0, 32'hff80_0000);

    // random phases over several configurations
    for (p = 0; p < 7; p++) begin
      case (p)
        0: begin cnt = 16; sat_v = 1'b1; end
        1: begin cnt = 2; sat_v = 1'b0; end
        2: begin cnt = 1; sat_v = 1'b1; end
        3: begin cnt = 0; sat_v = 1'b0; end
        4: begin cnt = 31; sat_v = 1'b1; end
        5: begin cnt = $urandom_range(3, 15); sat_v = $urandom_range(0, 1); end
        default: begin cnt = $urandom_range(0, 31); sat_v = $urandom_range(0, 1); end
      endcase
      wait_drained();
      reg_write(REG_POINT_COUNT, 32'(cnt));
      reg_write(REG_SATURATE, {31'd0, sat_v});
      n_eff = (cnt < 2) ? 2 : (cnt > MAX_PTS) ? MAX_PTS : cnt;
      load_sorted_table(p % 3);
      random_phase(PHASE_ITEMS, n_eff);
    end
    wait_drained();

    if (mismatches == 0 && expected_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pli_pkg.sv
rtl/core/pli_div.sv
rtl/core/piecewise_linear_interpolator.sv
dv/tb.sv
